FILE: rtl/median_filter_rgb_window_assert.svh
// Assertion helpers shared by the median filter RTL.
// Both sample on the rising clock edge and are switched off while reset is low.
`ifndef MEDIAN_FILTER_RGB_WINDOW_ASSERT_SVH
`define MEDIAN_FILTER_RGB_WINDOW_ASSERT_SVH

// prop must hold at every clock edge.
`define MFRW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expr must never be true at a clock edge.
`define MFRW_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: rtl/mfrw_pkg.sv
package mfrw_pkg;

  localparam int unsigned MFRW_MAX_WIDTH  = 1024;
  localparam int unsigned MFRW_MAX_RADIUS = 3;
  localparam int unsigned MFRW_MAX_HEIGHT = 4096;

  localparam int unsigned NUM_CH = 3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic [1:0]  RADIUS_RST = 2'd1;
  localparam logic [10:0] WIDTH_RST  = 11'd640;
  localparam logic [12:0] HEIGHT_RST = 13'd480;

  localparam logic KIND_PIXEL = 1'b0;

  typedef struct packed {
    logic       kind;
    logic [7:0] pix_r;
    logic [7:0] pix_g;
    logic [7:0] pix_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  med_r;
    logic [7:0]  med_g;
    logic [7:0]  med_b;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_frame;
  } out_item_t;

  // What one sorting cell shows its right-hand neighbor.
  typedef struct packed {
    logic                      valid;
    logic [NUM_CH-1:0]         take;
    logic [NUM_CH-1:0][7:0]    v;
  } sort_link_t;

endpackage

FILE: rtl/mfrw_stream_if.sv
interface mfrw_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/median_filter_rgb_window.sv
// Streaming RGB median filter over a square window clipped to the image.
// Pixels enter in raster order; results lag by radius rows plus radius
// columns and flush items drain the tail of a frame. An item that gives no
// result leaves the filter ready; one that gives a result holds off input
// until its clipped window (up to 49 pixels at a 7x7 window) is read and
// its result is loaded: the line store has one read port, so the window
// is read one pixel a cycle into a chain of insertion-sort cells, one cell
// per window position, and the median is picked from the chain. A finished
// result waits in the output register while the next item is taken. A
// radius, width or height register write restarts the frame.
module median_filter_rgb_window
  import mfrw_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MFRW_MAX_WIDTH,
  parameter int unsigned MAX_RADIUS = MFRW_MAX_RADIUS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [12:0]          cfg_data_i,
  mfrw_stream_if.sink          in_i,
  mfrw_stream_if.source        out_o
);

  `include "median_filter_rgb_window_assert.svh"

  localparam int unsigned ColW  = $clog2(MAX_WIDTH);
  localparam int unsigned RingW = $clog2(2 * MAX_RADIUS + 2);
  localparam int unsigned Win   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int unsigned CntW  = $clog2(Win + 1);
  localparam int unsigned AddrW = RingW + ColW;
  localparam int unsigned IdxW  = 12 + ColW;
  localparam int unsigned LagW  = ColW + 3;

  typedef enum logic [1:0] {S_IDLE, S_GATHER, S_DRAIN, S_EMIT} st_e;

  st_e             st_q;
  logic [1:0]      rad_q;
  logic [10:0]     wid_q;
  logic [12:0]     hgt_q;
  logic [11:0]     in_row_q, out_row_q, y_q, r1_q;
  logic [ColW-1:0] in_col_q, out_col_q, x_q, c0_q, c1_q;
  logic [IdxW-1:0] in_idx_q;
  logic            in_done_q, rd_v_q, out_valid_q;
  logic [CntW-1:0] cnt_q;
  out_item_t       out_q;

  logic [1:0]      eff_r;
  logic [ColW:0]   eff_w;
  logic [12:0]     eff_h;
  logic [LagW-1:0] lag;
  logic            acc, is_pix, emit, col_wrap, row_wrap, out_load, last;
  logic [ColW:0]   in_col_inc, c_sum, out_col_inc;
  logic [12:0]     in_row_inc, r_sum;
  logic [11:0]     r0;
  logic [11:0]     r1;
  logic [ColW-1:0] c0, c1;
  logic [23:0]     rdata;
  logic [NUM_CH-1:0][7:0] med;
  logic [CntW-1:0] mid;
  sort_link_t      link [Win+1];

  always_comb begin
    if (rad_q == 2'd0) begin
      eff_r = 2'd1;
    end else if (32'(rad_q) > MAX_RADIUS) begin
      eff_r = 2'(MAX_RADIUS);
    end else begin
      eff_r = rad_q;
    end
    if (wid_q == 11'd0) begin
      eff_w = (ColW + 1)'(1);
    end else if (32'(wid_q) > MAX_WIDTH) begin
      eff_w = (ColW + 1)'(MAX_WIDTH);
    end else begin
      eff_w = (ColW + 1)'(wid_q);
    end
    if (hgt_q == 13'd0) begin
      eff_h = 13'd1;
    end else if (32'(hgt_q) > MFRW_MAX_HEIGHT) begin
      eff_h = 13'(MFRW_MAX_HEIGHT);
    end else begin
      eff_h = hgt_q;
    end
  end

  assign acc    = in_i.valid && in_i.ready;
  assign is_pix = (in_i.data.kind == KIND_PIXEL) && !in_done_q;

  // A pixel gives a result once its raster index reaches radius rows plus
  // radius columns.
  assign lag  = (LagW'(eff_r) * LagW'(eff_w)) + LagW'(eff_r);
  assign emit = in_done_q || (is_pix && (in_idx_q >= IdxW'(lag)));

  assign in_col_inc = {1'b0, in_col_q} + 1'b1;
  assign in_row_inc = {1'b0, in_row_q} + 1'b1;
  assign col_wrap   = in_col_inc >= eff_w;
  assign row_wrap   = in_row_inc >= eff_h;

  // Window bounds, clipped to the frame.
  assign r_sum = {1'b0, out_row_q} + 13'(eff_r);
  assign c_sum = {1'b0, out_col_q} + (ColW + 1)'(eff_r);
  assign r0 = (out_row_q >= 12'(eff_r)) ? out_row_q - 12'(eff_r) : 12'd0;
  assign r1 = (r_sum < eff_h) ? r_sum[11:0] : 12'(eff_h - 13'd1);
  assign c0 = (out_col_q >= ColW'(eff_r)) ? out_col_q - ColW'(eff_r) : '0;
  assign c1 = (c_sum < eff_w) ? c_sum[ColW-1:0] : ColW'(eff_w - 1'b1);

  mfrw_ram #(
    .WIDTH (24),
    .DEPTH (2 ** AddrW)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (acc && is_pix),
    .waddr_i ({in_row_q[RingW-1:0], in_col_q}),
    .wdata_i ({in_i.data.pix_r, in_i.data.pix_g, in_i.data.pix_b}),
    .raddr_i ({y_q[RingW-1:0], x_q}),
    .rdata_o (rdata)
  );

  assign link[0] = '{valid: 1'b1, take: '0, v: '0};

  for (genvar k = 0; k < Win; k++) begin : g_cell
    mfrw_sort_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (acc),
      .ins_i  (rd_v_q),
      .x_i    ({rdata[23:16], rdata[15:8], rdata[7:0]}),
      .prev_i (link[k]),
      .link_o (link[k+1])
    );
  end

  assign mid = cnt_q >> 1;

  always_comb begin
    med = '0;
    for (int k = 0; k < Win; k++) begin
      if (CntW'(k) == mid) begin
        med = link[k+1].v;
      end
    end
  end

  assign out_col_inc = {1'b0, out_col_q} + 1'b1;
  assign last     = (r_sum[11:0] == out_row_q + 12'(eff_r)) &&
                    ({1'b0, out_row_q} == eff_h - 13'd1) && (out_col_inc == eff_w);
  assign out_load = (st_q == S_EMIT) && (!out_valid_q || out_o.ready);

  assign in_i.ready  = (st_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      rad_q       <= RADIUS_RST;
      wid_q       <= WIDTH_RST;
      hgt_q       <= HEIGHT_RST;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_idx_q    <= '0;
      in_done_q   <= 1'b0;
      out_row_q   <= '0;
      out_col_q   <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      rd_v_q <= (st_q == S_GATHER);
      if (rd_v_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (out_o.ready && !out_load) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIUS: rad_q <= cfg_data_i[1:0];
          CFG_WIDTH:  wid_q <= cfg_data_i[10:0];
          CFG_HEIGHT: hgt_q <= cfg_data_i;
          default: ;
        endcase
        if (cfg_idx_i == CFG_RADIUS || cfg_idx_i == CFG_WIDTH || cfg_idx_i == CFG_HEIGHT) begin
          in_row_q  <= '0;
          in_col_q  <= '0;
          in_idx_q  <= '0;
          in_done_q <= 1'b0;
          out_row_q <= '0;
          out_col_q <= '0;
        end
      end

      case (st_q)
        S_IDLE: begin
          if (acc) begin
            cnt_q <= '0;
            if (is_pix) begin
              in_idx_q <= in_idx_q + 1'b1;
              if (col_wrap) begin
                in_col_q <= '0;
                if (row_wrap) begin
                  in_row_q  <= '0;
                  in_done_q <= 1'b1;
                end else begin
                  in_row_q <= in_row_inc[11:0];
                end
              end else begin
                in_col_q <= in_col_inc[ColW-1:0];
              end
            end
            if (emit) begin
              y_q  <= r0;
              r1_q <= r1;
              x_q  <= c0;
              c0_q <= c0;
              c1_q <= c1;
              st_q <= S_GATHER;
            end
          end
        end
        S_GATHER: begin
          if (x_q == c1_q) begin
            x_q <= c0_q;
            if (y_q == r1_q) begin
              st_q <= S_DRAIN;
            end else begin
              y_q <= y_q + 1'b1;
            end
          end else begin
            x_q <= x_q + 1'b1;
          end
        end
        S_DRAIN: begin
          st_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q         <= 1'b1;
            out_q.med_r         <= med[2];
            out_q.med_g         <= med[1];
            out_q.med_b         <= med[0];
            out_q.out_row       <= out_row_q;
            out_q.out_col       <= 10'(out_col_q);
            out_q.last_of_frame <= last;
            if (last) begin
              in_row_q  <= '0;
              in_col_q  <= '0;
              in_idx_q  <= '0;
              in_done_q <= 1'b0;
              out_row_q <= '0;
              out_col_q <= '0;
            end else if (out_col_inc >= eff_w) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 1'b1;
            end else begin
              out_col_q <= out_col_inc[ColW-1:0];
            end
            st_q <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `MFRW_ASSERT(a_cnt_bound, cnt_q <= CntW'(Win), "window count exceeds the sorting chain")
  `MFRW_ASSERT_NEVER(a_emit_empty, (st_q == S_EMIT) && (cnt_q == '0), "median of empty window")
  `MFRW_ASSERT(a_gather_bounds, (st_q != S_GATHER) || ((y_q <= r1_q) && (x_q <= c1_q)), "window read outside bounds")
  `MFRW_ASSERT(a_last_restart, (out_load && last) |=> ((out_row_q == '0) && (out_col_q == '0) && !in_done_q), "frame did not restart after its last result")

endmodule

FILE: rtl/mfrw_ram.sv
module mfrw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 8192,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/mfrw_sort_cell.sv
module mfrw_sort_cell
  import mfrw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clr_i,
  input  logic                   ins_i,
  input  logic [NUM_CH-1:0][7:0] x_i,
  input  sort_link_t             prev_i,
  output sort_link_t             link_o
);

  logic                   valid_q;
  logic [NUM_CH-1:0][7:0] v_q;
  logic [NUM_CH-1:0]      take;

  // The new sample belongs at or left of this cell when the cell is empty
  // or holds a larger value; the cells stay sorted ascending.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      take[ch] = !valid_q || (x_i[ch] < v_q[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (ins_i) begin
      valid_q <= valid_q | prev_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (prev_i.take[ch]) begin
          v_q[ch] <= prev_i.v[ch];
        end else if (take[ch]) begin
          v_q[ch] <= x_i[ch];
        end
      end
    end
  end

  assign link_o.valid = valid_q;
  assign link_o.take  = take;
  assign link_o.v     = v_q;

endmodule

FILE: tb/tb.sv
module tb;
  import mfrw_pkg::*;

  localparam logic       KIND_FLUSH = 1'b1;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int         RING_ROWS  = 2 * MFRW_MAX_RADIUS + 2;
  localparam int         WIN_MAX    = (2 * MFRW_MAX_RADIUS + 1) * (2 * MFRW_MAX_RADIUS + 1);
  localparam int         STALL_LIMIT = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [12:0] cfg_data_i;

  mfrw_stream_if #(.payload_t(in_item_t))  in_if ();
  mfrw_stream_if #(.payload_t(out_item_t)) out_if ();

  median_filter_rgb_window u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Pixel stream predictor state.
  logic [23:0] line_mem [RING_ROWS * MFRW_MAX_WIDTH];
  logic [1:0]  radius_q;
  logic [10:0] width_q;
  logic [12:0] height_q;
  int unsigned in_row, in_col, out_row_cnt, out_col_cnt;
  bit          frame_in_done;

  in_item_t  pixel_q  [$];
  out_item_t median_q [$];

  int  mismatches;
  int  stall_cycles;
  int  items_total;
  bit  in_taken;
  int  in_gap;
  int  out_gap;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_radius();
    if (radius_q == 2'd0) return 1;
    return 32'(radius_q);
  endfunction

  function automatic int unsigned eff_width();
    if (width_q == 11'd0) return 1;
    if (width_q > MFRW_MAX_WIDTH) return MFRW_MAX_WIDTH;
    return 32'(width_q);
  endfunction

  function automatic int unsigned eff_height();
    if (height_q == 13'd0) return 1;
    if (height_q > MFRW_MAX_HEIGHT) return MFRW_MAX_HEIGHT;
    return 32'(height_q);
  endfunction

  function automatic void restart_frame();
    in_row = 0;
    in_col = 0;
    frame_in_done = 0;
    out_row_cnt = 0;
    out_col_cnt = 0;
  endfunction

  function automatic void apply_cfg(logic [1:0] idx, logic [12:0] data);
    case (idx)
      CFG_RADIUS: radius_q = data[1:0];
      CFG_WIDTH:  width_q  = data[10:0];
      CFG_HEIGHT: height_q = data[12:0];
      default: return;
    endcase
    restart_frame();
  endfunction

  function automatic logic [7:0] middle_of(int vals[WIN_MAX], int n);
    int i, j, t;
    for (i = 1; i < n; i++) begin
      t = vals[i];
      j = i;
      while (j > 0 && vals[j-1] > t) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = t;
    end
    return 8'(vals[n/2]);
  endfunction

  function automatic void emit_median();
    int unsigned rr, w, h, r, c, r0, r1, c0, c1, y, x;
    int vr [WIN_MAX];
    int vg [WIN_MAX];
    int vb [WIN_MAX];
    int n;
    logic [23:0] px;
    out_item_t res;
    bit last;
    rr = eff_radius();
    w = eff_width();
    h = eff_height();
    r = out_row_cnt;
    c = out_col_cnt;
    r0 = (r >= rr) ? r - rr : 0;
    r1 = (r + rr < h) ? r + rr : h - 1;
    c0 = (c >= rr) ? c - rr : 0;
    c1 = (c + rr < w) ? c + rr : w - 1;
    n = 0;
    for (y = r0; y <= r1; y++) begin
      for (x = c0; x <= c1; x++) begin
        px = line_mem[(y % RING_ROWS) * MFRW_MAX_WIDTH + (x % MFRW_MAX_WIDTH)];
        vr[n] = 32'(px[23:16]);
        vg[n] = 32'(px[15:8]);
        vb[n] = 32'(px[7:0]);
        n++;
      end
    end
    last = (r == h - 1) && (c == w - 1);
    res.med_r = middle_of(vr, n);
    res.med_g = middle_of(vg, n);
    res.med_b = middle_of(vb, n);
    res.out_row = r[11:0];
    res.out_col = c[9:0];
    res.last_of_frame = last;
    median_q.push_back(res);
    if (last) begin
      restart_frame();
    end else begin
      out_col_cnt++;
      if (out_col_cnt >= w) begin
        out_col_cnt = 0;
        out_row_cnt++;
      end
    end
  endfunction

  function automatic void apply_item(in_item_t it);
    int unsigned w, h, rr, lag, idx;
    w = eff_width();
    h = eff_height();
    rr = eff_radius();
    if (it.kind == KIND_PIXEL && !frame_in_done) begin
      lag = rr * w + rr;
      idx = in_row * w + in_col;
      line_mem[(in_row % RING_ROWS) * MFRW_MAX_WIDTH + (in_col % MFRW_MAX_WIDTH)] =
        {it.pix_r, it.pix_g, it.pix_b};
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_in_done = 1;
        end
      end
      if (idx >= lag) emit_median();
    end else if (frame_in_done) begin
      emit_median();
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 19);
    if (p < 13) return 0;
    if (p < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [7:0] rnd_sample();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_item_t make_pixel();
    in_item_t it;
    it.kind = KIND_PIXEL;
    it.pix_r = rnd_sample();
    it.pix_g = rnd_sample();
    it.pix_b = rnd_sample();
    return it;
  endfunction

  function automatic in_item_t make_flush();
    in_item_t it;
    it = make_pixel();
    it.kind = KIND_FLUSH;
    return it;
  endfunction

  // Input driver: a new item goes out once the previous one was transferred.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_taken)) begin
      in_taken = 0;
      if (in_gap > 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        in_if.data  <= pixel_q.pop_front();
        in_if.valid <= 1'b1;
        in_gap = pick_gap();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Output back-pressure.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // Prediction and checking at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      stall_cycles++;
      if (cfg_we_i) begin
        apply_cfg(cfg_idx_i, cfg_data_i);
        stall_cycles = 0;
      end
      if (in_if.valid && in_if.ready) begin
        apply_item(in_if.data);
        in_taken = 1;
        stall_cycles = 0;
      end
      if (out_if.valid && out_if.ready) begin
        stall_cycles = 0;
        if (median_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", out_if.data);
        end else begin
          out_item_t exp_res;
          exp_res = median_q.pop_front();
          if (out_if.data.med_r !== exp_res.med_r || out_if.data.med_g !== exp_res.med_g ||
              out_if.data.med_b !== exp_res.med_b || out_if.data.out_row !== exp_res.out_row ||
              out_if.data.out_col !== exp_res.out_col ||
              out_if.data.last_of_frame !== exp_res.last_of_frame) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p actual %p", exp_res, out_if.data);
          end
        end
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (pixel_q.size() > 0 || in_if.valid || median_q.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic setup(logic [1:0] r, logic [12:0] w, logic [12:0] h);
    wait_idle();
    write_reg(CFG_RADIUS, {11'd0, r});
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
  endtask

  task automatic push(in_item_t it);
    pixel_q.push_back(it);
    items_total++;
  endtask

  // One frame at the current settings, optionally cut short.
  task automatic send_frame(int unsigned w, int unsigned h, int unsigned rr, bit cut);
    int unsigned total, lag, tail, i, stop;
    total = w * h;
    lag = rr * w + rr;
    tail = (total < lag) ? total : lag;
    stop = cut ? $urandom_range(0, total) : total;
    for (i = 0; i < stop; i++) begin
      // Flushes inside the frame have no effect.
      if ($urandom_range(0, 15) == 0) push(make_flush());
      push(make_pixel());
    end
    if (!cut) begin
      for (i = 0; i < tail; i++) begin
        // A pixel past the frame end acts as a flush.
        if ($urandom_range(0, 4) == 0) push(make_pixel());
        else push(make_flush());
      end
      if ($urandom_range(0, 3) == 0) push(make_flush());
    end
  endtask

  initial begin
    int unsigned r, w, h, i;
    logic [12:0] wr, hr;
    mismatches = 0;
    stall_cycles = 0;
    items_total = 0;
    in_taken = 0;
    in_gap = 0;
    out_gap = 0;
    radius_q = RADIUS_RST;
    width_q = WIDTH_RST;
    height_q = HEIGHT_RST;
    restart_frame();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_RADIUS;
    cfg_data_i = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: an early flush does nothing, extremes of the samples.
    push(make_flush());
    push('{kind: KIND_PIXEL, pix_r: 8'h00, pix_g: 8'hFF, pix_b: 8'h00});
    push('{kind: KIND_PIXEL, pix_r: 8'hFF, pix_g: 8'h00, pix_b: 8'hFF});
    for (i = 0; i < 6; i++) push(make_pixel());

    // Largest window on a tiny frame, then out-of-range settings.
    setup(2'd3, 13'd4, 13'd3);
    send_frame(4, 3, 3, 0);
    setup(2'd0, 13'd0, 13'd0);
    send_frame(1, 1, 1, 0);
    wait_idle();
    write_reg(CFG_UNUSED, 13'h1FFF);
    send_frame(1, 1, 1, 0);

    // Widest and tallest frames, cut short.
    setup(2'd3, 13'd1024, 13'd4096);
    for (i = 0; i < 40; i++) push(make_pixel());
    setup(2'd2, 13'd2047, 13'd8191);
    for (i = 0; i < 40; i++) push(make_pixel());

    // Tall narrow frame reaches high row numbers.
    setup(2'd1, 13'd1, 13'd300);
    send_frame(1, 300, 1, 0);

    while (items_total < 1300) begin
      r = $urandom_range(0, 3);
      wr = 13'($urandom_range(0, 10));
      hr = 13'($urandom_range(0, 8));
      if ($urandom_range(0, 9) == 0) wr = 13'($urandom_range(11, 40));
      setup(r[1:0], wr, hr);
      w = (wr == 0) ? 1 : 32'(wr);
      h = (hr == 0) ? 1 : 32'(hr);
      if (r == 0) r = 1;
      send_frame(w, h, r, $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        send_frame(w, h, r, 0);
      end
    end

    wait_idle();
    if (mismatches == 0 && median_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/mfrw_pkg.sv
rtl/mfrw_stream_if.sv
rtl/mfrw_ram.sv
rtl/mfrw_sort_cell.sv
rtl/median_filter_rgb_window.sv
tb/tb.sv
